### design/sha1_message_digest_assert.svh
// Assertion macros for the SHA-1 digest port checker.
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SHA1MD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha1 digest check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SHA1MD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha1 digest check failed");

`endif

### design/sha1md_pkg.sv
// Shared types, constants and round functions for the SHA-1 digest block.
package sha1md_pkg;

    // Payload of one input transfer.
    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } in_item_t;

    // Payload of one output transfer.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    // Classified command handed from the front end to the engine.
    typedef enum logic {
        CMD_APPEND = 1'b0,
        CMD_FINISH = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    // Engine sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } eng_state_t;

    // Padding progress while a message is being finished.
    typedef enum logic [2:0] {
        PH_NONE,
        PH_MARK,
        PH_ZERO,
        PH_LEN,
        PH_DONE
    } pad_phase_t;

    // Command queue geometry.
    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    // Block and round geometry.
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned ROUND_W     = 7;
    localparam logic [ROUND_W-1:0] LAST_ROUND   = 7'd79;
    localparam logic [ROUND_W-1:0] SCHED_ROUNDS = 7'd16;

    // Padding constants.
    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [5:0] LEN_FILL     = 6'd56;
    localparam logic [5:0] FULL_FILL    = 6'd63;
    localparam logic [2:0] LAST_LEN_IDX = 3'd7;

    // Digest readout.
    localparam int unsigned DIGEST_WORDS = 5;
    localparam logic [2:0]  LAST_INDEX   = 3'd4;

    localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Boolean function of the round group.
    function automatic logic [31:0] round_f(
        input logic [ROUND_W-1:0] round,
        input logic [31:0]        b,
        input logic [31:0]        c,
        input logic [31:0]        d
    );
        logic [31:0] res;
        if (round < 7'd20) begin
            res = (b & c) | (~b & d);
        end else if (round < 7'd40) begin
            res = b ^ c ^ d;
        end else if (round < 7'd60) begin
            res = (b & c) | (b & d) | (c & d);
        end else begin
            res = b ^ c ^ d;
        end
        return res;
    endfunction

    // Additive constant of the round group.
    function automatic logic [31:0] round_k(input logic [ROUND_W-1:0] round);
        logic [31:0] res;
        if (round < 7'd20) begin
            res = 32'h5A827999;
        end else if (round < 7'd40) begin
            res = 32'h6ED9EBA1;
        end else if (round < 7'd60) begin
            res = 32'h8F1BBCDC;
        end else begin
            res = 32'hCA62C1D6;
        end
        return res;
    endfunction

endpackage

### design/sha1md_fifo.sv
// Short command queue between the front end and the digest engine.
module sha1md_fifo
    import sha1md_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    cmd_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/sha1md_front.sv
// Input stage: takes items, classifies them into engine commands.
module sha1md_front
    import sha1md_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output cmd_t     cmd
);

    cmd_t hold_reg;
    logic hold_valid_reg, hold_valid_next;
    logic in_xfer;
    cmd_t classified;

    assign in_ready  = !hold_valid_reg || cmd_ready;
    assign in_xfer   = in_valid && in_ready;
    assign cmd_valid = hold_valid_reg;
    assign cmd       = hold_reg;

    // A finish request carries no byte.
    always_comb
    begin
        classified.kind = in_data.mode ? CMD_FINISH : CMD_APPEND;
        classified.data = in_data.mode ? 8'h00 : in_data.data_byte;
    end

    always_comb
    begin
        if (in_xfer)
        begin
            hold_valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            hold_valid_next = 1'b0;
        end
        else
        begin
            hold_valid_next = hold_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            hold_reg <= classified;
        end
    end

endmodule

### design/sha1md_core.sv
// Digest engine: block packing, padding, 80-round compression and readout.
module sha1md_core
    import sha1md_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    // Control state.
    eng_state_t         state_reg, state_next;
    pad_phase_t         phase_reg, phase_next;
    logic [5:0]         fill_reg, fill_next;
    logic [60:0]        count_reg, count_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [2:0]         len_idx_reg, len_idx_next;
    logic [2:0]         out_idx_reg, out_idx_next;
    logic               out_valid_reg, out_valid_next;

    // Datapath state.
    logic [31:0]        blk_reg [BLOCK_WORDS];
    logic [31:0]        hash_reg [DIGEST_WORDS];
    logic [31:0]        a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [63:0]        len_reg, len_next;
    out_item_t          out_reg;

    // Strobes from the sequencer to the datapath.
    logic               wr_en;
    logic [7:0]         wr_byte;
    logic               block_full;
    logic               load_out;
    logic               hash_init;

    logic [31:0]        w_t;
    logic [31:0]        t_sum;
    logic [4:0]         byte_shift;
    logic [3:0]         wr_word;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        round_next     = round_reg;
        len_idx_next   = len_idx_reg;
        out_idx_next   = out_idx_reg;
        len_next       = len_reg;
        cmd_ready      = 1'b0;
        wr_en          = 1'b0;
        wr_byte        = 8'h00;
        load_out       = 1'b0;
        hash_init      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    if (cmd.kind == CMD_APPEND)
                    begin
                        wr_en      = 1'b1;
                        wr_byte    = cmd.data;
                        count_next = count_reg + 61'd1;
                    end
                    else
                    begin
                        len_next   = {count_reg, 3'b000};
                        phase_next = PH_MARK;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                unique case (phase_reg)
                    PH_MARK:
                    begin
                        wr_en      = 1'b1;
                        wr_byte    = PAD_MARK;
                        phase_next = PH_ZERO;
                    end
                    PH_ZERO:
                    begin
                        if (fill_reg == LEN_FILL)
                        begin
                            phase_next   = PH_LEN;
                            len_idx_next = '0;
                        end
                        else
                        begin
                            wr_en = 1'b1;
                        end
                    end
                    PH_LEN:
                    begin
                        wr_en        = 1'b1;
                        wr_byte      = len_reg[63:56];
                        len_next     = {len_reg[55:0], 8'h00};
                        len_idx_next = len_idx_reg + 3'd1;
                        if (len_idx_reg == LAST_LEN_IDX)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DONE:
                    begin
                        out_idx_next = '0;
                        state_next   = ST_OUT;
                    end
                    PH_NONE:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_ROUND:
            begin
                round_next = round_reg + 1'b1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                priority if (phase_reg == PH_NONE)
                begin
                    state_next = ST_IDLE;
                end
                else if (phase_reg == PH_DONE)
                begin
                    out_idx_next = '0;
                    state_next   = ST_OUT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out     = 1'b1;
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == LAST_INDEX)
                    begin
                        hash_init    = 1'b1;
                        count_next   = '0;
                        fill_next    = '0;
                        out_idx_next = '0;
                        phase_next   = PH_NONE;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Any byte write advances the fill; a full block starts compression.
        block_full = wr_en && (fill_reg == FULL_FILL);
        if (wr_en)
        begin
            fill_next = fill_reg + 6'd1;
        end
        if (block_full)
        begin
            round_next = '0;
            state_next = ST_ROUND;
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_NONE;
            fill_reg      <= '0;
            count_reg     <= '0;
            round_reg     <= '0;
            len_idx_reg   <= '0;
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            round_reg     <= round_next;
            len_idx_reg   <= len_idx_next;
            out_idx_reg   <= out_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Schedule word: the first sixteen come straight from the block window,
    // later ones are expanded from taps of the same window.
    assign w_t = (round_reg < SCHED_ROUNDS) ? blk_reg[0] :
                 {(blk_reg[13] ^ blk_reg[8] ^ blk_reg[2] ^ blk_reg[0]) << 1} |
                 {31'h0, (blk_reg[13][31] ^ blk_reg[8][31] ^ blk_reg[2][31] ^ blk_reg[0][31])};

    assign t_sum = {a_reg[26:0], a_reg[31:27]} + round_f(round_reg, b_reg, c_reg, d_reg)
                 + e_reg + round_k(round_reg) + w_t;

    // Big-endian byte placement within the current word.
    assign wr_word    = fill_reg[5:2];
    assign byte_shift = {~fill_reg[1:0], 3'b000};

    // Block window: byte writes while loading, shift line while compressing.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (fill_reg[1:0] == 2'b00)
            begin
                blk_reg[wr_word] <= {wr_byte, 24'h000000};
            end
            else
            begin
                blk_reg[wr_word] <= blk_reg[wr_word] | ({24'h000000, wr_byte} << byte_shift);
            end
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
            begin
                blk_reg[i] <= blk_reg[i+1];
            end
            blk_reg[BLOCK_WORDS-1] <= w_t;
        end
    end

    // Working variables.
    always_ff @(posedge clk)
    begin
        if (block_full)
        begin
            a_reg <= hash_reg[0];
            b_reg <= hash_reg[1];
            c_reg <= hash_reg[2];
            d_reg <= hash_reg[3];
            e_reg <= hash_reg[4];
        end
        else if (state_reg == ST_ROUND)
        begin
            a_reg <= t_sum;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // Chaining value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                hash_reg[i] <= H_INIT[i];
            end
        end
        else if (hash_init)
        begin
            for (int i = 0; i < DIGEST_WORDS; i++)
            begin
                hash_reg[i] <= H_INIT[i];
            end
        end
        else if (state_reg == ST_UPDATE)
        begin
            hash_reg[0] <= hash_reg[0] + a_reg;
            hash_reg[1] <= hash_reg[1] + b_reg;
            hash_reg[2] <= hash_reg[2] + c_reg;
            hash_reg[3] <= hash_reg[3] + d_reg;
            hash_reg[4] <= hash_reg[4] + e_reg;
        end
    end

    // Length shifter and output register.
    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        if (load_out)
        begin
            out_reg.digest_word <= hash_reg[out_idx_reg];
            out_reg.word_index  <= out_idx_reg;
            out_reg.last_word   <= (out_idx_reg == LAST_INDEX);
        end
    end

endmodule

### design/sha1_message_digest.sv
// Top level of the SHA-1 message digest block.
//
//   Channel | Signals                       | Payload
//   --------+-------------------------------+--------------------------------------
//   in      | in_valid, in_ready, in_data   | mode, data_byte
//   out     | out_valid, out_ready, out_data| digest_word, word_index, last_word
//
// The engine takes one appended byte at a time while idle; every 64th byte
// starts the 80 compression rounds and the chaining update on the single
// shared round unit, and no further byte is taken until they are done.
// A finish takes 1 to 2 blocks of padding plus five output transfers.
// Reset leaves the block ready at once with the standard initial hash.
// A two-entry command queue lets the input side keep taking transfers
// while the engine compresses or the output side stalls.
module sha1_message_digest
    import sha1md_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    // Front end: classify incoming transfers.
    sha1md_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Command queue.
    sha1md_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cmd_valid),
        .push_ready (cmd_ready),
        .push_data  (cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_cmd)
    );

    // Back end: packing, padding, compression and readout.
    sha1md_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### design/sha1md_checker.sv
// Port-level checks on the digest output sequence, bound to the top level.
`include "sha1_message_digest_assert.svh"

module sha1md_checker
    import sha1md_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data
);

    // A stalled output transfer keeps its word.
    `SHA1MD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

    // Word indexes stay within the digest.
    `SHA1MD_ASSERT_NOW(a_index_range, out_valid, out_data.word_index <= LAST_INDEX)

    // The last flag marks exactly the fifth word.
    `SHA1MD_ASSERT_NOW(a_last_flag, out_valid, out_data.last_word == (out_data.word_index == LAST_INDEX))

    // Digest words follow one another without a gap.
    `SHA1MD_ASSERT_NEXT(a_word_order, out_valid && out_ready && !out_data.last_word, out_valid && (out_data.word_index == $past(out_data.word_index) + 3'd1))

endmodule

bind sha1_message_digest sha1md_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

### bench/sha1_digest_checker.sv
// Checker for the SHA-1 digest block: predicts each digest from the input transfers and compares.
module sha1_digest_checker
    import sha1md_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        fail_count,
    output int        pending_words
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted hashing state: chaining value, block under assembly and message length.
    logic [31:0] chain_h [DIGEST_WORDS];
    logic [31:0] blk_w [BLOCK_WORDS];
    logic [5:0]  blk_fill;
    logic [60:0] msg_bytes;

    // Digest words predicted but not yet seen on the output channel.
    out_item_t   digest_q [$];

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] digest check: %s", $realtime, what);
        fail_count++;
    endtask

    // Start a new message from the standard initial hash.
    task automatic restart_message();
        for (int i = 0; i < DIGEST_WORDS; i++)
        begin
            chain_h[i] = H_INIT[i];
        end
        blk_fill  = '0;
        msg_bytes = '0;
    endtask

    // Run the 80 rounds over the assembled block and fold the result into the chain.
    task automatic compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = blk_w[i];
        end
        for (int i = 16; i < 80; i++)
        begin
            w[i] = rotl32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rotl32(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endtask

    // Pack one byte big-endian into the block; a full block is compressed at once.
    task automatic absorb_byte(input logic [7:0] v);
        int unsigned slot;
        int unsigned shamt;
        slot  = blk_fill[5:2];
        shamt = 8 * (3 - int'(blk_fill[1:0]));
        if (blk_fill[1:0] == 2'd0)
        begin
            blk_w[slot] = 32'(v) << shamt;
        end
        else
        begin
            blk_w[slot] |= 32'(v) << shamt;
        end
        blk_fill = blk_fill + 6'd1;
        if (blk_fill == 6'd0)
        begin
            compress_block();
        end
    endtask

    // Pad, append the bit length, queue the five digest words and reinitialize.
    task automatic close_message();
        logic [63:0] bit_len;
        out_item_t   word;
        bit_len = {msg_bytes, 3'b000};
        absorb_byte(PAD_MARK);
        // Too little room left for the length: pad out an extra block.
        if (blk_fill > LEN_FILL)
        begin
            while (blk_fill != 6'd0)
            begin
                absorb_byte(8'h00);
            end
        end
        while (blk_fill < LEN_FILL)
        begin
            absorb_byte(8'h00);
        end
        for (int s = 56; s >= 0; s -= 8)
        begin
            absorb_byte(bit_len[s +: 8]);
        end
        for (int i = 0; i < DIGEST_WORDS; i++)
        begin
            word.digest_word = chain_h[i];
            word.word_index  = 3'(i);
            word.last_word   = (3'(i) == LAST_INDEX);
            digest_q.push_back(word);
        end
        restart_message();
    endtask

    // Follow both channels; input transfers first, then match any output transfer.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            restart_message();
            digest_q.delete();
            fail_count    = 0;
            pending_words = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (in_data.mode == CMD_FINISH)
                begin
                    close_message();
                end
                else
                begin
                    absorb_byte(in_data.data_byte);
                    msg_bytes = msg_bytes + 61'd1;
                end
            end
            if (out_valid && out_ready)
            begin
                if (digest_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected output transfer, word %h index %0d",
                                              out_data.digest_word, out_data.word_index));
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (out_data.digest_word !== want.digest_word)
                    begin
                        report_mismatch($sformatf("word %0d: digest_word %h, predicted %h",
                                                  want.word_index, out_data.digest_word,
                                                  want.digest_word));
                    end
                    if (out_data.word_index !== want.word_index)
                    begin
                        report_mismatch($sformatf("word_index %0d, predicted %0d",
                                                  out_data.word_index, want.word_index));
                    end
                    if (out_data.last_word !== want.last_word)
                    begin
                        report_mismatch($sformatf("word %0d: last_word %b, predicted %b",
                                                  want.word_index, out_data.last_word,
                                                  want.last_word));
                    end
                end
            end
            pending_words = digest_q.size();
        end
    end

endmodule

### bench/tb_top.sv
// Top of the SHA-1 digest testbench: clock, reset, stimulus, output flow control and verdict.
module tb_top
    import sha1md_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int ITEM_TARGET   = 300;
    localparam int DIGEST_TARGET = 16;
    // Message lengths around the padding and block boundaries.
    localparam int CORNER_LENS [10] = '{0, 1, 54, 55, 56, 57, 63, 64, 65, 119};

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    int        fail_count;
    int        pending_words;
    int        cycle_count = 0;
    int        items_sent = 0;
    int        digests_asked = 0;

    // Sender keeps its own pacing flag; the receiver's copies change by NBA only.
    bit        tx_steady = 1'b0;
    bit        rx_steady = 1'b0;
    bit        hold_req = 1'b0;
    bit        hold_done = 1'b0;
    int        rx_wait = 0;
    int        rx_hold = 0;

    sha1_message_digest dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    sha1_digest_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Give up if the run hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Output flow control: per word a random number of stalled cycles while valid
    // is up (none when pacing is steady), plus one long hold requested by the stimulus.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait = $urandom_range(0, 3);
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                rx_wait = rx_steady ? 0 : $urandom_range(0, 3);
            end
            if (hold_req && !hold_done)
            begin
                rx_hold   = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_ready <= 1'b0;
            end
            else if (rx_wait > 0 && out_valid)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offer one item after a random gap (none when steady) and return at the edge of its transfer.
    task automatic send_item(input logic m, input logic [7:0] b);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{mode: m, data_byte: b};
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (m == CMD_FINISH)
        begin
            digests_asked++;
        end
    endtask

    // Random bytes followed by a finish whose data byte must be ignored.
    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_item(CMD_APPEND, 8'($urandom_range(0, 255)));
        end
        send_item(CMD_FINISH, 8'($urandom_range(0, 255)));
    endtask

    function automatic int pick_length();
        int len;
        if ($urandom_range(0, 3) == 0)
        begin
            len = CORNER_LENS[$urandom_range(0, 9)];
        end
        else
        begin
            len = $urandom_range(0, 40);
        end
        return len;
    endfunction

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Empty message, the classic three-byte message, extreme byte values,
        // and a finish right behind another finish.
        send_item(CMD_FINISH, 8'h00);
        send_item(CMD_APPEND, 8'h61);
        send_item(CMD_APPEND, 8'h62);
        send_item(CMD_APPEND, 8'h63);
        send_item(CMD_FINISH, 8'hFF);
        send_item(CMD_APPEND, 8'h00);
        send_item(CMD_APPEND, 8'hFF);
        send_item(CMD_FINISH, 8'h5A);
        send_item(CMD_FINISH, 8'hA5);

        // Long output hold while short messages keep coming, so the input backs up.
        tx_steady = 1'b1;
        rx_steady <= 1'b1;
        hold_req  <= 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            send_message($urandom_range(0, 2));
        end

        // Random messages, pacing switched per message.
        while (items_sent < ITEM_TARGET || digests_asked < DIGEST_TARGET)
        begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady <= tx_steady;
            send_message(pick_length());
        end
        in_valid <= 1'b0;

        // Drain the remaining digest words, then watch for stray output.
        @(posedge clk);
        while (pending_words != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
